[hw/rtl/ppr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_pkg: shared types, constants and functions
// Field widths, fixed-point formats, queue item layout and the semitone
// pitch-ratio functions of the portamento pitch ratio core.
// ----------------------------------------------------------------------------
package ppr_pkg;

    // Field widths
    localparam int KIND_W  = 1;
    localparam int NOTE_W  = 7;
    localparam int NUM_W   = 16;
    localparam int RATIO_W = 32;
    localparam int GLIDE_W = 16;
    localparam int RATE_W  = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_TIME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b1;
    localparam logic [GLIDE_W-1:0]   GLIDE_TIME_RESET  = 16'd0;
    localparam logic [RATE_W-1:0]    SAMPLE_RATE_RESET = 18'd44100;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_NOTE_ON = 1'b0;
    localparam logic [KIND_W-1:0] KIND_BLOCK   = 1'b1;

    // Fixed-point formats
    localparam int RATIO_FRAC_BITS = 21;
    localparam int TABLE_FRAC_BITS = 30;
    localparam int SLOPE_FRAC_BITS = 24;
    localparam int GLIDE_FRAC_BITS = 12;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

    // Glide counter: glide_time * sample_rate >> 12 fits in 22 bits
    localparam int PROD_W  = GLIDE_W + RATE_W;
    localparam int COUNT_W = PROD_W - GLIDE_FRAC_BITS;
    localparam int REM_W   = 24;
    localparam int CNT_W   = $clog2(SLOPE_FRAC_BITS + 1);

    // Note register: -1 means no note yet
    localparam logic signed [7:0] NOTE_NONE = -8'sd1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Pitch ratio shift: octave index 0..21 maps to octave -11..10
    localparam int SHIFT_BIAS = 11 + TABLE_FRAC_BITS - RATIO_FRAC_BITS;

    typedef struct packed {
        logic              is_block;
        logic [NOTE_W-1:0] note;
        logic [NUM_W-1:0]  num_samples;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic idle;
        logic emit;
    } back_status_t;

    // Octave index 0..21 and semitone step 0..11 of a pitch exponent
    typedef struct packed {
        logic [4:0] oct;
        logic [3:0] step;
    } pitch_idx_t;

    // 2^(step/12) in Q2.30
    function automatic logic [31:0] semitone_q30(input logic [3:0] step);
        logic [31:0] r;
        case (step)
            4'd0:    r = 32'd1073741824;
            4'd1:    r = 32'd1137589835;
            4'd2:    r = 32'd1205234447;
            4'd3:    r = 32'd1276901417;
            4'd4:    r = 32'd1352829926;
            4'd5:    r = 32'd1433273380;
            4'd6:    r = 32'd1518500250;
            4'd7:    r = 32'd1608794974;
            4'd8:    r = 32'd1704458901;
            4'd9:    r = 32'd1805811301;
            4'd10:   r = 32'd1913190429;
            4'd11:   r = 32'd2026954652;
            default: r = 32'd1073741824;
        endcase
        return r;
    endfunction

    // Split exponent e (signed -128..127) into octave index and semitone step
    function automatic pitch_idx_t pitch_index(input logic [7:0] e);
        logic [8:0]  t;
        logic [16:0] scaled;
        logic [8:0]  rest;
        pitch_idx_t  r;
        t      = {e[7], e} + 9'd132;
        // t / 12 by reciprocal multiply, exact for t < 260
        scaled = 17'(t) * 17'd171;
        r.oct  = scaled[15:11];
        rest   = t - 9'(r.oct) * 9'd12;
        r.step = rest[3:0];
        return r;
    endfunction

    // 2^(e/12) in ratio format from its split exponent, rounded half up, saturated
    function automatic logic [RATIO_W-1:0] pitch_scale(input pitch_idx_t idx);
        logic [31:0] base;
        logic [4:0]  amt;
        logic [39:0] v;
        base = semitone_q30(idx.step);
        if (idx.oct >= 5'(SHIFT_BIAS)) begin
            amt = idx.oct - 5'(SHIFT_BIAS);
            v   = 40'(base) << amt;
        end
        else begin
            amt = 5'(SHIFT_BIAS) - idx.oct;
            v   = (40'(base) + (40'd1 << (amt - 5'd1))) >> amt;
        end
        return (v > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

[hw/rtl/ppr_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_in_if: input item channel
// Valid/ready channel carrying item kind, note number and block length.
// ----------------------------------------------------------------------------
interface ppr_in_if;
    logic                        valid;
    logic                        ready;
    logic [ppr_pkg::KIND_W-1:0]  kind;
    logic [ppr_pkg::NOTE_W-1:0]  note;
    logic [ppr_pkg::NUM_W-1:0]   num_samples;

    modport source (output valid, output kind, output note, output num_samples,
                    input ready);
    modport sink   (input valid, input kind, input note, input num_samples,
                    output ready);
endinterface

[hw/rtl/ppr_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_out_if: result channel
// Valid/ready channel carrying the glide pitch ratio.
// ----------------------------------------------------------------------------
interface ppr_out_if;
    logic                        valid;
    logic                        ready;
    logic [ppr_pkg::RATIO_W-1:0] glide_ratio;

    modport source (output valid, output glide_ratio, input ready);
    modport sink   (input valid, input glide_ratio, output ready);
endinterface

[hw/rtl/ppr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_front: input stage and item queue
// Accepts input transfers, tags each as note-on or block request and
// holds them in a two-entry queue for the execution back end.
// ----------------------------------------------------------------------------
module ppr_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    ppr_in_if.sink               in_ch,
    output ppr_pkg::queue_head_t head,
    input  logic                 pop
);

    ppr_pkg::item_t                 slot_reg [ppr_pkg::QUEUE_DEPTH];
    logic [ppr_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ppr_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ppr_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           push;
    logic                           do_pop;
    ppr_pkg::item_t                 new_item;

    // Classify the incoming item
    always_comb
    begin
        new_item.is_block    = (in_ch.kind == ppr_pkg::KIND_BLOCK);
        new_item.note        = in_ch.note;
        new_item.num_samples = in_ch.num_samples;
    end

    assign in_ch.ready = (count_reg != ppr_pkg::QCNT_W'(ppr_pkg::QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign do_pop      = pop && (count_reg != '0);

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

endmodule

[hw/rtl/ppr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppr_back: glide execution engine
// Holds the note and glide state, serves note-on and block items from the
// queue with a radix-2 slope divider, a slope multiplier and a glide-length multiplier, and owns the
// result output register.
// ----------------------------------------------------------------------------
module ppr_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ppr_pkg::GLIDE_W-1:0]   glide_time,
    input  logic [ppr_pkg::RATE_W-1:0]    sample_rate,
    input  ppr_pkg::queue_head_t          head,
    output logic                          pop,
    output ppr_pkg::back_status_t         status,
    ppr_out_if.source                     out_ch
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_NOTE  = 8'b00000010,
        S_PITCH = 8'b00000100,
        S_CHECK = 8'b00001000,
        S_DIV   = 8'b00010000,
        S_MUL   = 8'b00100000,
        S_APPLY = 8'b01000000,
        S_EMIT  = 8'b10000000
    } state_t;

    localparam int QUOT_W = ppr_pkg::SLOPE_FRAC_BITS;
    localparam int MUL_W  = ppr_pkg::RATIO_W + QUOT_W;

    state_t                              state_reg, state_next;
    logic signed [7:0]                   cur_note_reg, cur_note_next;
    logic signed [7:0]                   prev_note_reg, prev_note_next;
    logic [ppr_pkg::RATIO_W-1:0]         start_ratio_reg, start_ratio_next;
    logic signed [ppr_pkg::REM_W-1:0]    remaining_reg, remaining_next;
    logic [ppr_pkg::CNT_W-1:0]           step_cnt_reg, step_cnt_next;
    logic                                out_valid_reg, out_valid_next;

    ppr_pkg::item_t                      item_reg, item_next;
    ppr_pkg::pitch_idx_t                 pitch_idx_reg, pitch_idx_next;
    logic [ppr_pkg::COUNT_W-1:0]         part_reg, part_next;
    logic [ppr_pkg::COUNT_W-1:0]         divisor_reg, divisor_next;
    logic [QUOT_W-1:0]                   quot_reg, quot_next;
    logic [MUL_W-1:0]                    prod_reg, prod_next;
    logic [ppr_pkg::RATIO_W-1:0]         result_reg, result_next;
    logic [ppr_pkg::RATIO_W-1:0]         out_data_reg, out_data_next;

    logic [8:0]                          note_diff;
    logic [8:0]                          neg_diff;
    logic [ppr_pkg::PROD_W-1:0]          glide_prod;
    logic                                unity_hold;
    logic [25:0]                         num_x10;
    logic [25:0]                         rem_x9;
    logic [ppr_pkg::COUNT_W+1:0]         trial;
    logic                                ratio_up;
    logic [ppr_pkg::RATIO_W-1:0]         ratio_diff;
    logic [ppr_pkg::RATIO_W-1:0]         delta;
    logic                                out_free;

    // Datapath terms
    always_comb
    begin
        note_diff  = {2'b00, item_reg.note} - {cur_note_reg[7], cur_note_reg};
        neg_diff   = 9'd0 - note_diff;
        glide_prod = ppr_pkg::PROD_W'(glide_time) * ppr_pkg::PROD_W'(sample_rate);
        unity_hold = (remaining_reg <= 24'sd0) || (prev_note_reg == ppr_pkg::NOTE_NONE)
                     || (glide_time == '0);
        num_x10    = 26'(item_reg.num_samples) * 26'd10;
        rem_x9     = 26'(remaining_reg[ppr_pkg::COUNT_W-1:0]) * 26'd9;
        trial      = {1'b0, part_reg, 1'b0} - {2'b00, divisor_reg};
        ratio_up   = (start_ratio_reg >= ppr_pkg::RATIO_ONE);
        ratio_diff = ratio_up ? start_ratio_reg - ppr_pkg::RATIO_ONE
                              : ppr_pkg::RATIO_ONE - start_ratio_reg;
        delta      = prod_reg[QUOT_W +: ppr_pkg::RATIO_W];
        out_free   = !out_valid_reg || out_ch.ready;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cur_note_next    = cur_note_reg;
        prev_note_next   = prev_note_reg;
        start_ratio_next = start_ratio_reg;
        remaining_next   = remaining_reg;
        step_cnt_next    = step_cnt_reg;
        out_valid_next   = out_valid_reg;
        item_next        = item_reg;
        pitch_idx_next   = pitch_idx_reg;
        part_next        = part_reg;
        divisor_next     = divisor_reg;
        quot_next        = quot_reg;
        prod_next        = prod_reg;
        result_next      = result_reg;
        out_data_next    = out_data_reg;
        pop              = 1'b0;

        // Result register drains on a completed output transfer
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    item_next  = head.item;
                    state_next = head.item.is_block ? S_CHECK : S_NOTE;
                end
            end
            S_NOTE:
            begin
                prev_note_next = cur_note_reg;
                cur_note_next  = signed'({1'b0, item_reg.note});
                pitch_idx_next = ppr_pkg::pitch_index(neg_diff[7:0]);
                if (note_diff == '0)
                begin
                    remaining_next = '0;
                end
                else
                begin
                    remaining_next = signed'({2'b00,
                        glide_prod[ppr_pkg::PROD_W-1:ppr_pkg::GLIDE_FRAC_BITS]});
                end
                state_next = S_PITCH;
            end
            S_PITCH:
            begin
                // Table lookup and octave shift of the split exponent
                start_ratio_next = ppr_pkg::pitch_scale(pitch_idx_reg);
                state_next       = S_IDLE;
            end
            S_CHECK:
            begin
                if (unity_hold)
                begin
                    result_next = ppr_pkg::RATIO_ONE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    remaining_next = remaining_reg
                                     - signed'({8'b0, item_reg.num_samples});
                    // Slope at or above 0.9 snaps straight to unity
                    if (num_x10 >= rem_x9)
                    begin
                        result_next = ppr_pkg::RATIO_ONE;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        part_next     = ppr_pkg::COUNT_W'(item_reg.num_samples);
                        divisor_next  = remaining_reg[ppr_pkg::COUNT_W-1:0];
                        quot_next     = '0;
                        step_cnt_next = ppr_pkg::CNT_W'(QUOT_W);
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // One quotient bit per cycle, restoring division
                if (!trial[ppr_pkg::COUNT_W+1])
                begin
                    part_next = trial[ppr_pkg::COUNT_W-1:0];
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    part_next = {part_reg[ppr_pkg::COUNT_W-2:0], 1'b0};
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                step_cnt_next = step_cnt_reg - 1'b1;
                if (step_cnt_reg == ppr_pkg::CNT_W'(1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = MUL_W'(ratio_diff) * MUL_W'(quot_reg);
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                result_next = ratio_up ? start_ratio_reg - delta : start_ratio_reg + delta;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and glide state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cur_note_reg    <= ppr_pkg::NOTE_NONE;
            prev_note_reg   <= ppr_pkg::NOTE_NONE;
            start_ratio_reg <= '0;
            remaining_reg   <= '0;
            step_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_note_reg    <= cur_note_next;
            prev_note_reg   <= prev_note_next;
            start_ratio_reg <= start_ratio_next;
            remaining_reg   <= remaining_next;
            step_cnt_reg    <= step_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pitch_idx_reg <= pitch_idx_next;
        part_reg      <= part_next;
        divisor_reg   <= divisor_next;
        quot_reg      <= quot_next;
        prod_reg      <= prod_next;
        result_reg    <= result_next;
        out_data_reg  <= out_data_next;
    end

    assign status.idle        = (state_reg == S_IDLE);
    assign status.emit        = (state_reg == S_EMIT);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.glide_ratio = out_data_reg;

endmodule

[hw/rtl/portamento_pitch_ratio_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// portamento_pitch_ratio_core: portamento glide pitch-ratio generator
// Note-on items load a semitone ratio and a glide length; block requests
// return the pitch multiplier for one audio block, in unsigned Q11.21.
// ----------------------------------------------------------------------------
//   Channel   Dir  Handshake       Payload
//   in_ch     in   valid / ready   kind, note, num_samples
//   out_ch    out  valid / ready   glide_ratio
//   cfg       in   cfg_we          cfg_index, cfg_wdata
//
// Note-on: no result; the note step updates the note state, then the ratio
// table lookup in the pitch step finishes the update.
// Block request: a unity result is emitted straight from the check; otherwise
// the radix-2 slope divider, the multiply and the apply steps come first.
// Items are served one at a time from a two-entry queue; input transfers
// continue while a result waits in the output register.
// Reset (rst_n, async, active low) clears notes to none, the glide count,
// the queue and the output register; glide_time to 0, sample_rate to 44100.
// ----------------------------------------------------------------------------
module portamento_pitch_ratio_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    ppr_in_if.sink                             in_ch,
    ppr_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [ppr_pkg::GLIDE_W-1:0]  glide_time_reg;
    logic [ppr_pkg::RATE_W-1:0]   sample_rate_reg;
    ppr_pkg::queue_head_t         head;
    logic                         pop;
    ppr_pkg::back_status_t        back_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glide_time_reg  <= ppr_pkg::GLIDE_TIME_RESET;
            sample_rate_reg <= ppr_pkg::SAMPLE_RATE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppr_pkg::CFG_GLIDE_TIME:  glide_time_reg  <= cfg_wdata[ppr_pkg::GLIDE_W-1:0];
                ppr_pkg::CFG_SAMPLE_RATE: sample_rate_reg <= cfg_wdata[ppr_pkg::RATE_W-1:0];
                default:                  ;
            endcase
        end
    end

    ppr_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .head  (head),
        .pop   (pop)
    );

    ppr_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .glide_time  (glide_time_reg),
        .sample_rate (sample_rate_reg),
        .head        (head),
        .pop         (pop),
        .status      (back_status),
        .out_ch      (out_ch)
    );

    // The back end only takes from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("pop from empty queue");

    // Items leave the queue only while the back end is idle
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> back_status.idle)
        else $error("pop while back end busy");

    // A result appears only out of the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
                     $rose(out_ch.valid) |-> $past(back_status.emit))
        else $error("result without emit step");

endmodule

[bench/glide_ratio_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glide_ratio_checker: result checker for the portamento pitch ratio core
// Watches the input, result and configuration ports, predicts every glide
// ratio from its own copy of the note, glide and configuration state, and
// compares each result transfer with the oldest predicted ratio.
// ----------------------------------------------------------------------------
module glide_ratio_checker
    import ppr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ppr_in_if                     in_ch,
    ppr_out_if                    out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    errors,
    output int                    pending
);

    // 2^(step/12) in Q2.30
    localparam logic [31:0] STEP_Q30 [12] = '{
        32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
        32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
        32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
    };

    // Predicted block state and configuration
    logic [GLIDE_W-1:0] glide_cfg;
    logic [RATE_W-1:0]  rate_cfg;
    int                 note_now;
    int                 note_prev;
    logic [RATIO_W-1:0] ratio_from;
    int                 glide_left;
    logic [RATIO_W-1:0] ratio_expected [$];
    logic [RATIO_W-1:0] ratio_want;

    // 2^(e/12) in ratio format, half-up rounding on right shifts
    function automatic logic [RATIO_W-1:0] semitone_ratio(input int e);
        int                t;
        int                sh;
        longint unsigned   v;
        t  = e + 132;
        sh = (t / 12) - 11 + RATIO_FRAC_BITS - TABLE_FRAC_BITS;
        v  = 64'(STEP_Q30[t % 12]);
        if (sh >= 0)
            v = v << sh;
        else
            v = (v + (64'd1 << (-sh - 1))) >> (-sh);
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[RATIO_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [RATIO_W-1:0] got,
                                   input logic [RATIO_W-1:0] want);
        $display("[%0t] MISMATCH %s: glide_ratio got 0x%08h want 0x%08h",
                 $time, what, got, want);
        errors++;
    endtask

    // Advance the predicted state by one accepted item
    task automatic glide_predict(input logic [KIND_W-1:0] kind,
                                 input logic [NOTE_W-1:0] note,
                                 input logic [NUM_W-1:0]  num);
        longint unsigned slope;
        longint unsigned step;
        logic [RATIO_W-1:0] r;
        if (kind == KIND_NOTE_ON)
        begin
            note_prev  = note_now;
            note_now   = int'(note);
            ratio_from = semitone_ratio(note_prev - note_now);
            if (note_now == note_prev)
                glide_left = 0;
            else
                glide_left = int'((64'(glide_cfg) * 64'(rate_cfg)) >> GLIDE_FRAC_BITS);
        end
        else
        begin
            r = RATIO_ONE;
            if (glide_left > 0 && note_prev != -1 && glide_cfg != '0)
            begin
                // near the end of the glide the slope snaps to one
                if (64'(num) * 10 < 64'(glide_left) * 9)
                begin
                    slope = (64'(num) << SLOPE_FRAC_BITS) / 64'(glide_left);
                    if (ratio_from >= RATIO_ONE)
                    begin
                        step = (64'(ratio_from - RATIO_ONE) * slope) >> SLOPE_FRAC_BITS;
                        r    = ratio_from - RATIO_W'(step);
                    end
                    else
                    begin
                        step = (64'(RATIO_ONE - ratio_from) * slope) >> SLOPE_FRAC_BITS;
                        r    = ratio_from + RATIO_W'(step);
                    end
                end
                glide_left = glide_left - int'(num);
            end
            ratio_expected.push_back(r);
        end
    endtask

    // Compare result transfers, track config writes, predict input transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glide_cfg  = GLIDE_TIME_RESET;
            rate_cfg   = SAMPLE_RATE_RESET;
            note_now   = -1;
            note_prev  = -1;
            ratio_from = '0;
            glide_left = 0;
            ratio_expected.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (ratio_expected.size() == 0)
                    report_mismatch("result with none expected", out_ch.glide_ratio, '0);
                else
                begin
                    ratio_want = ratio_expected.pop_front();
                    if (out_ch.glide_ratio !== ratio_want)
                        report_mismatch("wrong ratio", out_ch.glide_ratio, ratio_want);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GLIDE_TIME:  glide_cfg = cfg_wdata[GLIDE_W-1:0];
                    CFG_SAMPLE_RATE: rate_cfg  = cfg_wdata[RATE_W-1:0];
                    default:         ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                glide_predict(in_ch.kind, in_ch.note, in_ch.num_samples);
            pending = ratio_expected.size();
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the portamento pitch ratio core
// Drives directed and random note-on and block items through several glide
// settings with random idle bursts on both channels; the checker predicts
// and compares every ratio, and this module prints the verdict.
// ----------------------------------------------------------------------------
module tb;
    import ppr_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int DRAIN       = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    errors;
    int                    pending;
    int                    cycles = 0;
    bit                    calm   = 1'b0;
    logic [NOTE_W-1:0]     last_note = '0;

    ppr_in_if  in_ch ();
    ppr_out_if out_ch ();

    portamento_pitch_ratio_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    glide_ratio_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("portamento_pitch_ratio_core test failed");
            $finish;
        end
    end

    // Result side: random stall bursts, none once calm
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    // One input transfer, with an optional idle burst ahead of it
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [NOTE_W-1:0] note,
                             input logic [NUM_W-1:0] num);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.kind        = kind;
        in_ch.note        = note;
        in_ch.num_samples = num;
        if (kind == KIND_NOTE_ON)
            last_note = note;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Hold off until every ratio has come back and the core is quiet
    task automatic settle();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Random phase: mostly note-on followed by a run of blocks, some noise
    task automatic run_phase(input logic [GLIDE_W-1:0] glide, input logic [RATE_W-1:0] rate,
                             input int count);
        int                sent;
        int                nblk;
        int                lim;
        int                pick;
        longint            span;
        logic [NOTE_W-1:0] nn;
        logic [NUM_W-1:0]  len;
        settle();
        write_reg(CFG_GLIDE_TIME, CFG_DATA_W'(glide));
        write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(rate));
        span = (longint'(glide) * longint'(rate)) >> GLIDE_FRAC_BITS;
        lim  = (span / 3 > 65535) ? 65535 : ((span / 3 < 1) ? 1 : int'(span / 3));
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                nn = ($urandom_range(0, 7) == 0) ? last_note : NOTE_W'($urandom);
                send_item(KIND_NOTE_ON, nn, NUM_W'($urandom));
                nblk = $urandom_range(1, 8);
                repeat (nblk)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        len = '0;
                    else if (pick < 3)
                        len = NUM_W'($urandom);
                    else
                        len = NUM_W'($urandom_range(0, lim));
                    send_item(KIND_BLOCK, NOTE_W'($urandom), len);
                end
                sent += nblk + 1;
            end
            else
            begin
                send_item(KIND_W'($urandom), NOTE_W'($urandom), NUM_W'($urandom));
                sent++;
            end
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_NOTE_ON;
        in_ch.note        = '0;
        in_ch.num_samples = '0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_GLIDE_TIME;
        cfg_wdata         = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // blocks before any note, reset configuration
        send_item(KIND_BLOCK, '0, '0);
        send_item(KIND_BLOCK, 7'h7F, 16'hFFFF);
        settle();

        // quarter-second glide at 44100: 11025 samples per glide
        write_reg(CFG_GLIDE_TIME, 18'h00400);
        send_item(KIND_NOTE_ON, 7'd127, 16'hFFFF);  // no previous note
        send_item(KIND_BLOCK, '0, 16'd100);
        send_item(KIND_NOTE_ON, 7'd0, '0);          // largest upward ratio
        send_item(KIND_BLOCK, '0, 16'd0);           // zero-length block
        send_item(KIND_BLOCK, '0, 16'd1000);
        send_item(KIND_BLOCK, '0, 16'd9000);
        send_item(KIND_BLOCK, '0, 16'hFFFF);        // overruns the glide
        send_item(KIND_BLOCK, '0, 16'd5);           // count spent
        send_item(KIND_NOTE_ON, 7'd127, '0);        // smallest ratio
        send_item(KIND_BLOCK, '0, 16'd4000);
        send_item(KIND_BLOCK, '0, 16'd3000);
        send_item(KIND_BLOCK, '0, 16'd3622);        // just under the snap point
        send_item(KIND_BLOCK, '0, 16'd363);         // just at the snap point
        send_item(KIND_NOTE_ON, 7'd127, '0);        // same note, no glide
        send_item(KIND_BLOCK, '0, 16'd10);
        send_item(KIND_NOTE_ON, 7'd64, '0);
        send_item(KIND_BLOCK, '0, 16'd2000);
        settle();

        // glide switched off mid-glide
        write_reg(CFG_GLIDE_TIME, '0);
        send_item(KIND_BLOCK, '0, 16'd50);
        send_item(KIND_NOTE_ON, 7'd5, '0);
        settle();

        // zero sample rate gives a zero count
        write_reg(CFG_GLIDE_TIME, 18'h00800);
        write_reg(CFG_SAMPLE_RATE, '0);
        send_item(KIND_NOTE_ON, 7'd100, '0);
        send_item(KIND_BLOCK, '0, 16'd1);

        run_phase(16'h0199, 18'd44100, 110);
        run_phase(16'hFFFF, 18'h3FFFF, 100);
        run_phase(16'd1, 18'd8000, 100);
        run_phase(GLIDE_W'($urandom), '0, 90);
        run_phase(GLIDE_W'($urandom_range(1, 65535)), 18'd192000, 110);
        run_phase(GLIDE_W'($urandom), RATE_W'($urandom_range(8000, 192000)), 110);
        run_phase('0, RATE_W'($urandom_range(8000, 192000)), 80);
        calm = 1'b1;
        run_phase(GLIDE_W'($urandom_range(16'h0100, 16'h2000)),
                  RATE_W'($urandom_range(8000, 192000)), 130);
        settle();

        if (errors == 0 && pending == 0)
            $display("portamento_pitch_ratio_core test passed");
        else
            $display("portamento_pitch_ratio_core test failed");
        $finish;
    end

endmodule
